// File: hdl/tbsa_pkg.sv
// ----------------------------------------------------------------------------
// tbsa_pkg
// Shared codes, sizes and the cell control bundle of the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package tbsa_pkg;

  // default bank size
  localparam int TBSA_NUM_TIMERS = 16;

  // field widths
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 6;
  localparam int PERIOD_W = 32;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 6;

  // input action codes
  localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_CREATED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FAILED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OK        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRY    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

  // control bundle broadcast from the sequencer to every cell
  typedef struct packed {
    logic clear;        // free every slot
    logic start;        // start the addressed slot
    logic stop;         // stop the addressed slot
    logic shift;        // move the sweep token one cell along
    logic seed;         // token entering the first cell
    logic flush;        // drop the token everywhere
    logic create_step;  // token cell claims itself if free
    logic tick_step;    // token cell advances its count
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/tbsa_cell.sv
// ----------------------------------------------------------------------------
// tbsa_cell
// One timer slot: its state, its share of the sweep token and its update.
// ----------------------------------------------------------------------------
`default_nettype none

module tbsa_cell
  import tbsa_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cell_ctl_t           ctl,
  input  wire logic [INDEX_W-1:0]  timer_index,
  input  wire logic [PERIOD_W-1:0] period,
  input  wire logic                one_shot,
  input  wire logic                start_now,
  input  wire logic                tok_in,
  output logic                     tok_out,
  output logic                     used_out,
  output logic                     free_hit,
  output logic                     expire
);

  logic                used;
  logic                running;
  logic                one_shot_mode;
  logic [PERIOD_W-1:0] count;
  logic [PERIOD_W-1:0] period_ticks;
  logic                tok;
  logic [PERIOD_W-1:0] count_inc;
  logic                addressed;

  // local decode and increment
  assign addressed = (timer_index == INDEX_W'(IDX));
  assign count_inc = count + 1'b1;
  assign free_hit  = tok && !used;
  assign expire    = tok && used && running && (count_inc >= period_ticks);
  assign tok_out   = tok;
  assign used_out  = used;

  // sweep token, handed on from the lower neighbour
  always_ff @(posedge clk) begin
    if (rst || ctl.flush) begin
      tok <= 1'b0;
    end else if (ctl.shift) begin
      tok <= tok_in;
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      used          <= 1'b0;
      running       <= 1'b0;
      one_shot_mode <= 1'b0;
      count         <= '0;
    end else if (ctl.start && addressed && used) begin
      count   <= '0;
      running <= 1'b1;
    end else if (ctl.stop && addressed) begin
      running <= 1'b0;
    end else if (ctl.create_step && free_hit) begin
      used          <= 1'b1;
      one_shot_mode <= one_shot;
      count         <= '0;
      running       <= start_now;
    end else if (ctl.tick_step && tok && used && running) begin
      if (expire) begin
        count <= '0;
        if (one_shot_mode) begin
          running <= 1'b0;
        end
      end else begin
        count <= count_inc;
      end
    end
  end

  // period store, written only on create
  always_ff @(posedge clk) begin
    if (ctl.create_step && free_hit) begin
      period_ticks <= period;
    end
  end

endmodule

`default_nettype wire

// File: hdl/timer_bank_with_slot_allocation_core.sv
// Bank of NUM_TIMERS software-style timers held in a row of slot cells. Start,
// stop and clear each give one result beat. Create and tick pass a one-hot
// token along the row, one slot per cycle while the result side does not
// stall: create stops at the first free slot, tick visits every slot and gives
// an expiry beat for each running slot whose count reaches its period, then a
// tick-done beat.
// ----------------------------------------------------------------------------
// timer_bank_with_slot_allocation_core
// Timer bank top level: request sequencer, result register and cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_bank_with_slot_allocation_core
  import tbsa_pkg::*;
#(
  parameter int NUM_TIMERS = TBSA_NUM_TIMERS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [INDEX_W-1:0]  timer_index,
  input  wire logic [PERIOD_W-1:0] period,
  input  wire logic                one_shot,
  input  wire logic                start_now,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [KIND_W-1:0]        kind,
  output logic [SLOT_W-1:0]        slot,
  output logic                     last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PW = $clog2(NUM_TIMERS + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                state;
  logic                state_next;
  logic                op_tick;
  logic [PW-1:0]       pos;
  logic [PERIOD_W-1:0] create_period;
  logic                create_one_shot;
  logic                create_start_now;

  logic                out_free;
  logic                in_fire;
  logic                adv;
  logic                sweep_end;
  logic                slot_ok;
  logic                any_free;
  logic                any_expire;
  cell_ctl_t           ctl;

  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [SLOT_W-1:0]   emit_slot;
  logic                emit_last;

  logic [NUM_TIMERS-1:0] tok_chain;
  logic [NUM_TIMERS-1:0] used_vec;
  logic [NUM_TIMERS-1:0] free_vec;
  logic [NUM_TIMERS-1:0] expire_vec;

  // handshake
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == ST_IDLE) && out_free);
  assign in_fire   = in_valid && !in_stall;
  assign adv       = (state == ST_SWEEP) && out_free;
  assign sweep_end = (pos == PW'(NUM_TIMERS));
  assign any_free  = |free_vec;
  assign any_expire = |expire_vec;
  assign slot_ok   = (timer_index < INDEX_W'(NUM_TIMERS)) && used_vec[timer_index[IW-1:0]];

  // sequencer decode
  always_comb begin
    ctl        = '0;
    emit       = 1'b0;
    emit_kind  = KIND_OK;
    emit_slot  = '0;
    emit_last  = 1'b1;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (action)
            ACT_CREATE: begin
              if (period == '0) begin
                emit      = 1'b1;
                emit_kind = KIND_FAILED;
              end else begin
                ctl.shift  = 1'b1;
                ctl.seed   = 1'b1;
                state_next = ST_SWEEP;
              end
            end
            ACT_START, ACT_STOP: begin
              emit       = 1'b1;
              emit_kind  = slot_ok ? KIND_OK : KIND_BAD;
              ctl.start  = slot_ok && (action == ACT_START);
              ctl.stop   = slot_ok && (action == ACT_STOP);
            end
            ACT_TICK: begin
              ctl.shift  = 1'b1;
              ctl.seed   = 1'b1;
              state_next = ST_SWEEP;
            end
            ACT_CLEAR: begin
              emit      = 1'b1;
              emit_kind = KIND_OK;
              ctl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (adv) begin
          if (sweep_end) begin
            emit       = 1'b1;
            emit_kind  = op_tick ? KIND_TICK_DONE : KIND_FAILED;
            state_next = ST_IDLE;
          end else if (op_tick) begin
            ctl.tick_step = 1'b1;
            ctl.shift     = 1'b1;
            if (any_expire) begin
              emit      = 1'b1;
              emit_kind = KIND_EXPIRY;
              emit_slot = SLOT_W'(pos);
              emit_last = 1'b0;
            end
          end else begin
            ctl.create_step = 1'b1;
            if (any_free) begin
              emit       = 1'b1;
              emit_kind  = KIND_CREATED;
              emit_slot  = SLOT_W'(pos);
              ctl.flush  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              ctl.shift = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        pos <= '0;
      end else if (ctl.shift) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_tick          <= (action == ACT_TICK);
      create_period    <= period;
      create_one_shot  <= one_shot;
      create_start_now <= start_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind <= emit_kind;
      slot <= emit_slot;
      last <= emit_last;
    end
  end

  // row of slot cells, token passed from each to the next
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    tbsa_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .timer_index(timer_index),
      .period     (create_period),
      .one_shot   (create_one_shot),
      .start_now  (create_start_now),
      .tok_in     ((i == 0) ? ctl.seed : tok_chain[(i == 0) ? 0 : i - 1]),
      .tok_out    (tok_chain[i]),
      .used_out   (used_vec[i]),
      .free_hit   (free_vec[i]),
      .expire     (expire_vec[i])
    );
  end

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer bank: create, start, stop, tick and clear
// requests are driven over the request channel. A local copy of the slot
// state predicts every result beat, and each beat is checked field by field
// as it leaves the block, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tbsa_pkg::*;

  localparam int NUM_SLOTS = TBSA_NUM_TIMERS;

  // length of the long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 300;

  // action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action = ACT_CLEAR;
  logic [INDEX_W-1:0]  timer_index = '0;
  logic [PERIOD_W-1:0] period = '0;
  logic                one_shot = 1'b0;
  logic                start_now = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot;
  logic                last;

  // predicted slot state
  logic                slot_busy   [NUM_SLOTS];
  logic                slot_live   [NUM_SLOTS];
  logic                slot_single [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_count  [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_period [NUM_SLOTS];

  result_beat_t pending_results[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_count = 0;
  int hold_req = 0;
  int hold_ack = 0;

  timer_bank_with_slot_allocation_core #(
    .NUM_TIMERS(NUM_SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .timer_index(timer_index),
    .period(period),
    .one_shot(one_shot),
    .start_now(start_now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .slot(slot),
    .last(last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("timer_bank_with_slot_allocation_core regression: fail");
    $finish;
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_count <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_count != 0) begin
      out_stall <= 1'b1;
      hold_count <= hold_count - 1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void queue_result(input logic [KIND_W-1:0] k, input int s,
                                       input logic l);
    result_beat_t beat;
    beat.kind = k;
    beat.slot = SLOT_W'(s);
    beat.last = l;
    pending_results.push_back(beat);
  endfunction

  function automatic void clear_slots();
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_live[i] = 1'b0;
      slot_single[i] = 1'b0;
      slot_count[i] = '0;
    end
  endfunction

  // works out the result beats of one accepted request and updates the slots
  function automatic void predict_timer_results(input logic [ACTION_W-1:0] act,
                                                input logic [INDEX_W-1:0] idx,
                                                input logic [PERIOD_W-1:0] per,
                                                input logic os, input logic sn);
    int i;
    logic placed;
    logic [PERIOD_W-1:0] next_count;
    case (act)
      ACT_CREATE: begin
        // first free slot, zero period never placed
        placed = 1'b0;
        if (per != '0) begin
          for (i = 0; i < NUM_SLOTS && !placed; i++) begin
            if (!slot_busy[i]) begin
              slot_busy[i] = 1'b1;
              slot_single[i] = os;
              slot_period[i] = per;
              slot_count[i] = '0;
              slot_live[i] = sn;
              queue_result(KIND_CREATED, i, 1'b1);
              placed = 1'b1;
            end
          end
        end
        if (!placed) queue_result(KIND_FAILED, 0, 1'b1);
      end
      ACT_START, ACT_STOP: begin
        if (idx >= NUM_SLOTS || !slot_busy[idx]) begin
          queue_result(KIND_BAD, 0, 1'b1);
        end else begin
          if (act == ACT_START) begin
            slot_count[idx] = '0;
            slot_live[idx] = 1'b1;
          end else begin
            slot_live[idx] = 1'b0;
          end
          queue_result(KIND_OK, 0, 1'b1);
        end
      end
      ACT_TICK: begin
        // sweep in slot order, expiries first then the done beat
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i] && slot_live[i]) begin
            next_count = slot_count[i] + 1'b1;
            if (next_count >= slot_period[i]) begin
              next_count = '0;
              queue_result(KIND_EXPIRY, i, 1'b0);
              if (slot_single[i]) slot_live[i] = 1'b0;
            end
            slot_count[i] = next_count;
          end
        end
        queue_result(KIND_TICK_DONE, 0, 1'b1);
      end
      ACT_CLEAR: begin
        clear_slots();
        queue_result(KIND_OK, 0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // predict on every accepted request, check every accepted result
  always @(posedge clk) begin : result_check
    result_beat_t want_beat;
    if (!rst) begin
      if (in_valid && !in_stall)
        predict_timer_results(action, timer_index, period, one_shot, start_now);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual kind %0d slot %0d last %0d",
                   $time, kind, slot, last);
          fail_count++;
        end else begin
          want_beat = pending_results.pop_front();
          check_field("kind", want_beat.kind, kind);
          check_field("slot", want_beat.slot, slot);
          check_field("last", want_beat.last, last);
        end
      end
    end
  end

  // offer one request beat after an optional random gap, return once accepted
  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                           input logic [PERIOD_W-1:0] per, input logic os, input logic sn);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    timer_index <= idx;
    period <= per;
    one_shot <= os;
    start_now <= sn;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every predicted beat has arrived, then a little more
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (NUM_SLOTS + 4) @(posedge clk);
  endtask

  function automatic int pick_index();
    int used_list[$];
    int i;
    if ($urandom_range(4) != 0) begin
      for (i = 0; i < NUM_SLOTS; i++)
        if (slot_busy[i]) used_list.push_back(i);
      if (used_list.size() != 0) return used_list[$urandom_range(used_list.size() - 1)];
    end
    if ($urandom_range(1) != 0) return $urandom_range(NUM_SLOTS - 1);
    return $urandom_range((1 << INDEX_W) - 1);
  endfunction

  // sends NUM_SLOTS + 1 creates: enough to fill an empty bank and one more
  task automatic fill_bank();
    repeat (NUM_SLOTS + 1)
      send_beat(ACT_CREATE, INDEX_W'($urandom), PERIOD_W'($urandom_range(8, 1)),
                1'($urandom), 1'($urandom));
  endtask

  task automatic random_beat();
    int r;
    logic [PERIOD_W-1:0] per;
    r = $urandom_range(99);
    per = $urandom;
    if (r < 22) begin
      // mostly short periods so expiries are frequent
      if ($urandom_range(7) != 0) per = $urandom_range(6, 1);
      else if ($urandom_range(3) == 0) per = '0;
      send_beat(ACT_CREATE, INDEX_W'($urandom), per, 1'($urandom), 1'($urandom));
    end else if (r < 34) begin
      send_beat(ACT_START, INDEX_W'(pick_index()), per, 1'($urandom), 1'($urandom));
    end else if (r < 44) begin
      send_beat(ACT_STOP, INDEX_W'(pick_index()), per, 1'($urandom), 1'($urandom));
    end else if (r < 88) begin
      send_beat(ACT_TICK, INDEX_W'($urandom), per, 1'($urandom), 1'($urandom));
    end else if (r < 92) begin
      send_beat(ACT_CLEAR, INDEX_W'($urandom), per, 1'($urandom), 1'($urandom));
    end else if (r < 96) begin
      send_beat(ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)), INDEX_W'($urandom),
                per, 1'($urandom), 1'($urandom));
    end else begin
      fill_bank();
    end
  endtask

  // every action and the corner cases, one after another
  task automatic test_directed_ops();
    send_idle_pct = 0;
    stall_pct = 0;
    send_beat(ACT_CLEAR, '0, '0, 1'b0, 1'b0);
    send_beat(ACT_TICK, '0, '0, 1'b0, 1'b0);
    send_beat(ACT_START, '0, '0, 1'b0, 1'b0);
    send_beat(ACT_STOP, '1, '0, 1'b0, 1'b0);
    send_beat(ACT_CREATE, '0, '0, 1'b0, 1'b1);
    send_beat(ACT_CREATE, '0, 32'd1, 1'b0, 1'b1);
    send_beat(ACT_CREATE, '1, '1, 1'b1, 1'b0);
    send_beat(ACT_CREATE, '0, 32'd2, 1'b1, 1'b1);
    repeat (3) send_beat(ACT_TICK, '0, '0, 1'b0, 1'b0);
    repeat (2) send_beat(ACT_STOP, '0, '0, 1'b0, 1'b0);
    send_beat(ACT_START, INDEX_W'(1), '0, 1'b0, 1'b0);
    send_beat(ACT_START, INDEX_W'(NUM_SLOTS), '0, 1'b0, 1'b0);
    send_beat(ACT_UNUSED_LO, '0, '0, 1'b0, 1'b0);
    send_beat(ACT_UNUSED_HI, '1, '1, 1'b1, 1'b1);
    send_beat(ACT_TICK, '1, '1, 1'b1, 1'b1);
    send_beat(ACT_CLEAR, '1, '1, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(input int beats, input int idle_pct, input int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    repeat (beats) random_beat();
    drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    fill_bank();
    repeat (23) random_beat();
    drain();
  endtask

  initial begin
    clear_slots();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_random_traffic(60, 0, 0);
    test_random_traffic(60, 68, 0);
    test_random_traffic(60, 0, 68);
    test_backpressure();
    test_random_traffic(60, 36, 36);
    if (fail_count == 0)
      $display("timer_bank_with_slot_allocation_core regression: pass");
    else
      $display("timer_bank_with_slot_allocation_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
